// ===== rtl/cbq_pkg.sv =====
// Shared constants, codes and command type for the cascaded biquad filter.
`default_nettype none

package cbq_pkg;

   // Default number of cascaded sections
   localparam int SECTIONS_DEF = 4;
   // Section index width; the command format can address up to 8 sections
   localparam int SEC_IDX_W = 3;

   // Coefficient slots per section
   localparam int SLOTS = 5;
   localparam int SLOT_W = 3;
   localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

   // Item kinds carried in req_tuser
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_COEF = 1'b1;

   // Number formats
   localparam int SAMPLE_W = 24;   // Q16.8
   localparam int COEF_W = 20;     // Q4.16
   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int ACC_W = PROD_W + 3;
   localparam int FRAC_SHIFT = 16;
   localparam int ROUND_HALF = 2 ** (FRAC_SHIFT - 1);
   localparam int RQ_W = ACC_W + 1 - FRAC_SHIFT;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Flat address width wide enough for any section and slot
   localparam int ADDR_FULL_W = 6;

   // Samples after reset that only fill the input history
   localparam int STARTUP_SAMPLES = 2;

   // Controller to datapath commands
   typedef struct packed {
      logic                  load_sample;
      logic                  coef_wr;
      logic                  mac_issue;
      logic                  acc_clr;
      logic                  round;
      logic                  out_load;
      logic                  out_zero;
      logic [SEC_IDX_W-1:0]  sec;
      logic [SLOT_W-1:0]     slot;
   } cbq_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/cascaded_biquad_iir_filter_unit.sv =====
// Each section runs 5 taps through one shared 20x24 multiplier, then drains the product and
// accumulate stages and rounds; after the last section the result goes to rsp_tdata.
// No new item is taken while a sample is in flight or its result waits for the output register;
// startup samples skip the sections, and coefficient writes are taken back to back.
// Reset (synchronous): clears coefficient valid bits, histories, startup count and handshakes;
// no clearing pass, the block takes items in the first cycle after reset.
`default_nettype none

module cascaded_biquad_iir_filter_unit #(
   parameter int SECTIONS = cbq_pkg::SECTIONS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // [23:0] sample, [26:24] coef_section, [29:27] coef_slot, [49:30] coef_value, [55:50] zero
   input  wire logic [55:0]   req_tdata,
   // [0] mode
   input  wire logic          req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // [23:0] filtered
   output logic [23:0]        rsp_tdata,
   // [0] saturated
   output logic               rsp_tuser
);
   import cbq_pkg::*;

   cbq_cmd_type                 cmd;
   logic signed [SAMPLE_W-1:0]  sample;
   logic [SEC_IDX_W-1:0]        coef_section;
   logic [SLOT_W-1:0]           coef_slot;
   logic signed [COEF_W-1:0]    coef_value;
   logic signed [SAMPLE_W-1:0]  filtered;
   logic                        saturated;

   // Unpack request fields
   assign sample       = req_tdata[23:0];
   assign coef_section = req_tdata[26:24];
   assign coef_slot    = req_tdata[29:27];
   assign coef_value   = req_tdata[49:30];

   assign rsp_tdata = filtered;
   assign rsp_tuser = saturated;

   cbq_ctrl #(
      .SECTIONS (SECTIONS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd_o      (cmd)
   );

   cbq_dpath #(
      .SECTIONS (SECTIONS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd_i        (cmd),
      .sample       (sample),
      .coef_section (coef_section),
      .coef_slot    (coef_slot),
      .coef_value   (coef_value),
      .filtered     (filtered),
      .saturated    (saturated)
   );

endmodule

`default_nettype wire

// ===== rtl/cbq_ctrl.sv =====
// Sequencer for the biquad cascade: handshakes, section and tap counting.
`default_nettype none

module cbq_ctrl #(
   parameter int SECTIONS = cbq_pkg::SECTIONS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_mode,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output cbq_pkg::cbq_cmd_type    cmd_o
);
   import cbq_pkg::*;

   localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_WAIT,
      S_ROUND,
      S_OUT
   } state_type;

   state_type          state_ff;
   logic [SEC_W-1:0]   sec_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               wait_ff;
   logic [1:0]         startup_ff;
   logic               zero_ff;
   logic               rsp_valid_ff;

   logic req_fire;
   logic rsp_fire;
   logic out_free;
   logic last_sec;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_sec   = (sec_ff == SEC_W'(SECTIONS - 1));

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sec_ff       <= '0;
         slot_ff      <= SLOT_B0;
         wait_ff      <= 1'b0;
         startup_ff   <= '0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_OUT the case arm below decides the valid flag
         if (rsp_fire && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && req_mode == MODE_SAMPLE) begin
                  sec_ff  <= '0;
                  slot_ff <= SLOT_B0;
                  if (startup_ff < 2'(STARTUP_SAMPLES)) begin
                     startup_ff <= startup_ff + 2'd1;
                     zero_ff    <= 1'b1;
                     state_ff   <= S_OUT;
                  end else begin
                     zero_ff  <= 1'b0;
                     state_ff <= S_MAC;
                  end
               end
            end
            S_MAC: begin
               if (slot_ff == SLOT_A2) begin
                  wait_ff  <= 1'b0;
                  state_ff <= S_WAIT;
               end else begin
                  slot_ff <= slot_ff + 3'd1;
               end
            end
            S_WAIT: begin
               // wait for the product and accumulate stages to drain
               if (wait_ff) begin
                  state_ff <= S_ROUND;
               end else begin
                  wait_ff <= 1'b1;
               end
            end
            S_ROUND: begin
               if (last_sec) begin
                  state_ff <= S_OUT;
               end else begin
                  sec_ff   <= sec_ff + SEC_W'(1);
                  slot_ff  <= SLOT_B0;
                  state_ff <= S_MAC;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Command decode
   always_comb begin
      cmd_o             = '0;
      cmd_o.sec         = SEC_IDX_W'(sec_ff);
      cmd_o.slot        = slot_ff;
      cmd_o.load_sample = req_fire && (req_mode == MODE_SAMPLE);
      cmd_o.coef_wr     = req_fire && (req_mode == MODE_COEF);
      cmd_o.mac_issue   = (state_ff == S_MAC);
      cmd_o.acc_clr     = (state_ff == S_MAC) && (slot_ff == SLOT_B0);
      cmd_o.round       = (state_ff == S_ROUND);
      cmd_o.out_load    = (state_ff == S_OUT) && out_free;
      cmd_o.out_zero    = zero_ff;
   end

   // Checks
   a_round_after_last_tap: assert property (@(posedge clock) disable iff (reset)
      (cmd_o.mac_issue && cmd_o.slot == SLOT_A2) |-> ##3 cmd_o.round)
      else $error("round not three cycles after last tap");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_o.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before transfer");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd_o.mac_issue || cmd_o.round) |-> !req_tready)
      else $error("input ready while computing");

   a_startup_bound: assert property (@(posedge clock) disable iff (reset)
      startup_ff <= 2'(STARTUP_SAMPLES))
      else $error("startup count past limit");

endmodule

`default_nettype wire

// ===== rtl/cbq_dpath.sv =====
// Datapath: coefficient memory, histories, shared multiply-accumulate, round and clip.
`default_nettype none

module cbq_dpath #(
   parameter int SECTIONS = cbq_pkg::SECTIONS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire cbq_pkg::cbq_cmd_type                    cmd_i,
   input  wire logic signed [cbq_pkg::SAMPLE_W-1:0]     sample,
   input  wire logic [cbq_pkg::SEC_IDX_W-1:0]           coef_section,
   input  wire logic [cbq_pkg::SLOT_W-1:0]              coef_slot,
   input  wire logic signed [cbq_pkg::COEF_W-1:0]       coef_value,
   output logic signed [cbq_pkg::SAMPLE_W-1:0]          filtered,
   output logic                                         saturated
);
   import cbq_pkg::*;

   localparam int COEFS = SLOTS * SECTIONS;
   localparam int AW = $clog2(COEFS);
   localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

   // Coefficient memory with per-entry valid bits (unwritten reads as zero)
   logic signed [COEF_W-1:0]  coef_mem [COEFS];
   logic [COEFS-1:0]          coef_vld_ff;
   logic signed [COEF_W-1:0]  coef_rd_ff;
   logic                      rd_vld_ff;

   logic [ADDR_FULL_W-1:0]    wr_full;
   logic [ADDR_FULL_W-1:0]    rd_full;
   logic [AW-1:0]             wr_addr;
   logic [AW-1:0]             rd_addr;
   logic                      wr_ok;
   logic [SEC_W-1:0]          sec;

   // Histories and working registers
   logic signed [SAMPLE_W-1:0] in_h0_ff;
   logic signed [SAMPLE_W-1:0] in_h1_ff;
   logic signed [SAMPLE_W-1:0] y1_ff [SECTIONS];
   logic signed [SAMPLE_W-1:0] y2_ff [SECTIONS];
   logic signed [SAMPLE_W-1:0] x0_ff;
   logic signed [SAMPLE_W-1:0] xh1_ff;
   logic signed [SAMPLE_W-1:0] xh2_ff;
   logic                       sat_ff;

   // MAC pipeline
   logic signed [SAMPLE_W-1:0] opnd_in;
   logic signed [SAMPLE_W-1:0] opnd_ff;
   logic                       neg1_ff;
   logic                       v1_ff;
   logic signed [COEF_W-1:0]   coef_eff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       neg2_ff;
   logic                       v2_ff;
   logic signed [ACC_W-1:0]    acc_ff;

   // Round and clip
   logic signed [ACC_W:0]      rsum;
   logic [RQ_W-1:0]            rq;
   logic [RQ_W-SAMPLE_W:0]     rq_hi;
   logic                       clip;
   logic signed [SAMPLE_W-1:0] y;

   assign sec     = cmd_i.sec[SEC_W-1:0];
   assign wr_full = ADDR_FULL_W'(coef_section) * ADDR_FULL_W'(SLOTS)
                    + ADDR_FULL_W'(coef_slot);
   assign rd_full = ADDR_FULL_W'(cmd_i.sec) * ADDR_FULL_W'(SLOTS)
                    + ADDR_FULL_W'(cmd_i.slot);
   assign wr_addr = wr_full[AW-1:0];
   assign rd_addr = rd_full[AW-1:0];
   assign wr_ok   = cmd_i.coef_wr && (int'(coef_section) < SECTIONS)
                    && (int'(coef_slot) < SLOTS);

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         coef_mem[wr_addr] <= coef_value;
      end
      coef_rd_ff <= coef_mem[rd_addr];
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (wr_ok) begin
            coef_vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= coef_vld_ff[rd_addr];
      end
   end

   // Operand select for the issued tap
   always_comb begin
      case (cmd_i.slot)
         SLOT_B0: opnd_in = x0_ff;
         SLOT_B1: opnd_in = xh1_ff;
         SLOT_B2: opnd_in = xh2_ff;
         SLOT_A1: opnd_in = y1_ff[sec];
         default: opnd_in = y2_ff[sec];
      endcase
   end

   assign coef_eff = rd_vld_ff ? coef_rd_ff : '0;

   // MAC stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd_i.mac_issue;
         v2_ff <= v1_ff;
      end
   end

   // Operand, product and accumulate stages
   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
      neg1_ff <= (cmd_i.slot == SLOT_A1) || (cmd_i.slot == SLOT_A2);
      prod_ff <= coef_eff * opnd_ff;
      neg2_ff <= neg1_ff;
      if (cmd_i.acc_clr) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         if (neg2_ff) begin
            acc_ff <= acc_ff - ACC_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // Round half up to Q16.8, then saturate
   always_comb begin
      rsum  = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(ROUND_HALF);
      rq    = rsum[ACC_W:FRAC_SHIFT];
      rq_hi = rq[RQ_W-1:SAMPLE_W-1];
      clip  = !((&rq_hi) || (~|rq_hi));
      if (clip) begin
         y = rq[RQ_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         y = rq[SAMPLE_W-1:0];
      end
   end

   // Histories and clip flag
   always_ff @(posedge clock) begin
      if (reset) begin
         in_h0_ff <= '0;
         in_h1_ff <= '0;
         sat_ff   <= 1'b0;
         for (int i = 0; i < SECTIONS; i++) begin
            y1_ff[i] <= '0;
            y2_ff[i] <= '0;
         end
      end else begin
         if (cmd_i.load_sample) begin
            in_h0_ff <= sample;
            in_h1_ff <= in_h0_ff;
            sat_ff   <= 1'b0;
         end
         if (cmd_i.round) begin
            y1_ff[sec] <= y;
            y2_ff[sec] <= y1_ff[sec];
            if (clip) begin
               sat_ff <= 1'b1;
            end
         end
      end
   end

   // Section input taps: sample on load, then each section's output history
   always_ff @(posedge clock) begin
      if (cmd_i.load_sample) begin
         x0_ff  <= sample;
         xh1_ff <= in_h0_ff;
         xh2_ff <= in_h1_ff;
      end else if (cmd_i.round) begin
         x0_ff  <= y;
         xh1_ff <= y1_ff[sec];
         xh2_ff <= y2_ff[sec];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd_i.out_load) begin
         filtered  <= cmd_i.out_zero ? '0 : x0_ff;
         saturated <= cmd_i.out_zero ? 1'b0 : sat_ff;
      end
   end

   // Checks
   a_round_pipeline_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_i.round |-> (!v1_ff && !v2_ff))
      else $error("round while products still in flight");

   a_load_not_during_mac: assert property (@(posedge clock) disable iff (reset)
      cmd_i.load_sample |-> (!cmd_i.mac_issue && !v1_ff && !v2_ff))
      else $error("sample loaded during accumulation");

   a_wr_not_during_mac: assert property (@(posedge clock) disable iff (reset)
      wr_ok |-> (!v1_ff && !cmd_i.mac_issue))
      else $error("coefficient write during accumulation");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the cascaded biquad IIR filter unit.
`default_nettype none

module tb;
   import cbq_pkg::*;

   localparam int N_SEC = SECTIONS_DEF;
   localparam int RANDOM_ITEMS = 550;
   // Cycles a sample occupies the block when the output does not stall, transfer to next transfer
   localparam int SAMPLE_CYCLES = 8 * N_SEC + 2;

   // One input item before packing
   typedef struct {
      logic                mode;
      logic [SAMPLE_W-1:0] sample;
      logic [SEC_IDX_W-1:0] sec;
      logic [SLOT_W-1:0]   slot;
      logic [COEF_W-1:0]   coef;
   } filt_item_type;

   // One result item
   typedef struct {
      logic [SAMPLE_W-1:0] filtered;
      logic                saturated;
   } filt_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [55:0]        req_tdata = '0;
   logic               req_tuser = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [23:0]        rsp_tdata;
   logic               rsp_tuser;

   cascaded_biquad_iir_filter_unit #(
      .SECTIONS(N_SEC)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // 10-unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Items waiting to be driven and results waiting to arrive
   filt_item_type pending_items[$];
   filt_out_type  filtered_q[$];

   // Filter state mirrored by the predictor
   logic signed [COEF_W-1:0]   coef_mem [N_SEC*SLOTS];
   logic signed [SAMPLE_W-1:0] x_hist [2];
   logic signed [SAMPLE_W-1:0] y_hist [2*N_SEC];
   int                         warmup_cnt = 0;

   int errors = 0;
   int n_counted = 0;
   int n_samples = 0;
   int n_coef_wr = 0;
   int n_ignored_wr = 0;
   int n_clipped = 0;

   initial begin
      for (int i = 0; i < N_SEC*SLOTS; i++) coef_mem[i] = '0;
      for (int i = 0; i < 2*N_SEC; i++) y_hist[i] = '0;
      x_hist[0] = '0;
      x_hist[1] = '0;
   end

   // Coefficient write into the mirrored store; out-of-range addresses drop
   function automatic void store_coef(logic [SEC_IDX_W-1:0] sec, logic [SLOT_W-1:0] slot,
                                      logic [COEF_W-1:0] value);
      if (int'(sec) < N_SEC && int'(slot) < SLOTS)
         coef_mem[int'(sec)*SLOTS + int'(slot)] = value;
   endfunction

   // Run one sample through the mirrored cascade
   function automatic filt_out_type filter_sample(logic signed [SAMPLE_W-1:0] x_in);
      filt_out_type r;
      longint acc;
      longint rq;
      logic signed [SAMPLE_W-1:0] x0, x1, x2, y1, y2, y;
      r.filtered = '0;
      r.saturated = 1'b0;
      if (warmup_cnt < STARTUP_SAMPLES) begin
         warmup_cnt++;
         x_hist[1] = x_hist[0];
         x_hist[0] = x_in;
         return r;
      end
      x0 = x_in;
      x1 = x_hist[0];
      x2 = x_hist[1];
      x_hist[1] = x_hist[0];
      x_hist[0] = x_in;
      for (int j = 0; j < N_SEC; j++) begin
         y1 = y_hist[2*j];
         y2 = y_hist[2*j+1];
         acc = longint'(coef_mem[j*SLOTS + int'(SLOT_B0)]) * longint'(x0)
             + longint'(coef_mem[j*SLOTS + int'(SLOT_B1)]) * longint'(x1)
             + longint'(coef_mem[j*SLOTS + int'(SLOT_B2)]) * longint'(x2)
             - longint'(coef_mem[j*SLOTS + int'(SLOT_A1)]) * longint'(y1)
             - longint'(coef_mem[j*SLOTS + int'(SLOT_A2)]) * longint'(y2);
         // round half up to Q16.8, then clip
         rq = (acc + longint'(ROUND_HALF)) >>> FRAC_SHIFT;
         if (rq > longint'(SAMPLE_MAX)) begin
            y = SAMPLE_MAX;
            r.saturated = 1'b1;
         end else if (rq < longint'(SAMPLE_MIN)) begin
            y = SAMPLE_MIN;
            r.saturated = 1'b1;
         end else begin
            y = SAMPLE_W'(rq);
         end
         y_hist[2*j+1] = y1;
         y_hist[2*j] = y;
         x0 = y;
         x1 = y1;
         x2 = y2;
      end
      r.filtered = x0;
      return r;
   endfunction

   // Random idle length: mostly none or short, a few long; none in calm stretches
   logic calm = 1'b0;
   int   calm_cnt = 0;

   always @(posedge clock) begin
      if (calm_cnt == 0) begin
         calm <= ($urandom_range(0, 3) == 0);
         calm_cnt <= $urandom_range(50, 400);
      end else begin
         calm_cnt <= calm_cnt - 1;
      end
   end

   function automatic int pick_gap();
      int p;
      if (calm) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [COEF_W-1:0] rand_coef(int span);
      int v;
      v = int'($urandom_range(0, 2*span)) - span;
      return COEF_W'(v);
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      int p;
      p = $urandom_range(0, 9);
      if (p < 5) return SAMPLE_W'($urandom());
      if (p < 8) return SAMPLE_W'(int'($urandom_range(0, 8192)) - 4096);
      return p[0] ? SAMPLE_MAX : SAMPLE_MIN;
   endfunction

   // Queue a sample; the coefficient fields carry random junk
   task automatic push_sample(input logic [SAMPLE_W-1:0] s);
      filt_item_type it;
      it.mode = MODE_SAMPLE;
      it.sample = s;
      it.sec = SEC_IDX_W'($urandom());
      it.slot = SLOT_W'($urandom());
      it.coef = COEF_W'($urandom());
      pending_items.insert(pending_items.size(), it);
      n_counted++;
   endtask

   // Queue a coefficient write; the sample field carries random junk
   task automatic push_coef(input logic [SEC_IDX_W-1:0] sec, input logic [SLOT_W-1:0] slot,
                            input logic [COEF_W-1:0] value);
      filt_item_type it;
      it.mode = MODE_COEF;
      it.sample = SAMPLE_W'($urandom());
      it.sec = sec;
      it.slot = slot;
      it.coef = value;
      pending_items.insert(pending_items.size(), it);
      if (int'(sec) < N_SEC && int'(slot) < SLOTS) n_counted++;
   endtask

   // Request driver: one item per transfer, random gap after each
   filt_item_type drv_item;
   int            req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_items.size() != 0) begin
            drv_item = pending_items[0];
            pending_items.delete(0);
            req_tdata <= {6'b0, drv_item.coef, drv_item.slot, drv_item.sec, drv_item.sample};
            req_tuser <= drv_item.mode;
            req_tvalid <= 1'b1;
            req_gap <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Predict at each accepted request transfer
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         if (req_tuser == MODE_COEF) begin
            if (int'(req_tdata[26:24]) < N_SEC && int'(req_tdata[29:27]) < SLOTS)
               n_coef_wr++;
            else
               n_ignored_wr++;
            store_coef(req_tdata[26:24], req_tdata[29:27], req_tdata[49:30]);
         end else begin
            n_samples++;
            filtered_q.insert(filtered_q.size(), filter_sample(req_tdata[23:0]));
         end
      end
   end

   // Response side: random back-pressure and result check
   filt_out_type want;
   int           rsp_stall = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_q.size() == 0) begin
               $display("%0t: unexpected result filtered=%h saturated=%b",
                        $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = filtered_q[0];
               filtered_q.delete(0);
               if (rsp_tuser) n_clipped++;
               if (rsp_tdata !== want.filtered) begin
                  $display("%0t: filtered mismatch: expected %h, actual %h",
                           $time, want.filtered, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser !== want.saturated) begin
                  $display("%0t: saturated mismatch: expected %b, actual %b",
                           $time, want.saturated, rsp_tuser);
                  errors++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall <= pick_gap();
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int kind;
      int burst;
      // startup: extremes only fill the input history
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      // all coefficients zero: output zero whatever the input
      push_sample(SAMPLE_MAX);
      // identity cascade
      for (int j = 0; j < N_SEC; j++) push_coef(SEC_IDX_W'(j), SLOT_B0, COEF_W'(65536));
      // writes to a missing section or slot are dropped
      push_coef(SEC_IDX_W'(N_SEC), SLOT_B0, COEF_W'(-524288));
      push_coef(3'd7, SLOT_A2, COEF_W'(524287));
      push_coef(3'd0, 3'd5, COEF_W'(524287));
      push_coef(3'd0, 3'd7, COEF_W'(-524288));
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      push_sample(24'sd1);
      push_sample(-24'sd1);
      // extreme feed-forward taps drive the first section into clipping
      push_coef(3'd0, SLOT_B1, COEF_W'(524287));
      push_coef(3'd0, SLOT_B2, COEF_W'(-524288));
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      // extreme feedback in the last section
      push_coef(SEC_IDX_W'(N_SEC-1), SLOT_A1, COEF_W'(-524288));
      push_coef(SEC_IDX_W'(N_SEC-1), SLOT_A2, COEF_W'(524287));
      push_sample(24'sd256);
      push_sample(SAMPLE_MIN);
      push_sample(24'sd0);

      // random phases: coefficient set, then a burst of samples
      while (n_counted < RANDOM_ITEMS + 25) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            // well-behaved filter
            for (int j = 0; j < N_SEC; j++) begin
               if ($urandom_range(0, 3) != 0) begin
                  push_coef(SEC_IDX_W'(j), SLOT_B0, rand_coef(16384));
                  push_coef(SEC_IDX_W'(j), SLOT_B1, rand_coef(16384));
                  push_coef(SEC_IDX_W'(j), SLOT_B2, rand_coef(16384));
                  push_coef(SEC_IDX_W'(j), SLOT_A1, rand_coef(32768));
                  push_coef(SEC_IDX_W'(j), SLOT_A2, rand_coef(16384));
               end
            end
         end else if (kind < 7) begin
            // full-range coefficients, heavy clipping
            for (int j = 0; j < N_SEC; j++)
               for (int s = 0; s < SLOTS; s++)
                  push_coef(SEC_IDX_W'(j), SLOT_W'(s), COEF_W'($urandom()));
         end else if (kind < 9) begin
            // scattered writes, some to missing addresses
            for (int k = $urandom_range(1, 4); k > 0; k--)
               push_coef(SEC_IDX_W'($urandom()), SLOT_W'($urandom()), COEF_W'($urandom()));
         end
         burst = $urandom_range(5, 30);
         for (int k = 0; k < burst; k++) push_sample(rand_sample());
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (pending_items.size() != 0 || req_tvalid);
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (4 * SAMPLE_CYCLES) @(posedge clock);

      $display("Ran %0d samples (%0d clipped) and %0d coefficient writes, %0d of them dropped.",
               n_samples, n_clipped, n_coef_wr + n_ignored_wr, n_ignored_wr);
      $display("Startup, identity, extreme taps and random filters seen with random stalls.");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("Timeout with %0d results outstanding", filtered_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
